/* hw/rtl/mt64_pkg.sv */
package mt64_pkg;

  localparam int unsigned TableLen = 312;
  localparam int unsigned MidStd   = 156;
  localparam int unsigned TapA     = 63;
  localparam int unsigned TapB     = 151;
  localparam int unsigned TapC     = 224;

  localparam logic [63:0] MAT_STD   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] MAT_DENSE = 64'hB3815B624FC82E2F;
  localparam logic [63:0] MUL_STD   = 64'd6364136223846793005;
  localparam logic [63:0] MUL_DENSE = 64'd2862933555777941757;
  localparam logic [63:0] SEED_RESET = 64'd5489;

  localparam logic REG_SEED    = 1'b0;
  localparam logic REG_VARIANT = 1'b1;

  typedef logic [8:0] pos_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_GEN
  } state_t;

  function automatic logic [63:0] temper(input logic [63:0] x_in, input logic dense);
    logic [63:0] x;
    x = x_in;
    if (!dense) begin
      x = x ^ ((x >> 29) & 64'h5555555555555555);
      x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
      x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
      x = x ^ (x >> 43);
    end else begin
      x = x ^ (x >> 26);
      x = x ^ ((x << 17) & 64'h599CFCBFCA660000);
      x = x ^ ((x << 33) & 64'hFFFAAFFE00000000);
      x = x ^ (x >> 39);
    end
    return x;
  endfunction

endpackage

/* hw/rtl/mt64_req_if.sv */
interface mt64_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* hw/rtl/mt64_rsp_if.sv */
interface mt64_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

/* hw/rtl/mt64_cell.sv */
module mt64_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [63:0] d,
  output logic [63:0] q
);
  // One table word; moves one place toward the head on each shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end
endmodule

/* hw/rtl/mt64_mul.sv */
module mt64_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] c,
  output logic        done,
  output logic [63:0] p
);
  // Low 64 bits of a*c from three 32x32 partial products, one per cycle.
  logic [1:0]  step;
  logic [63:0] a_q;
  logic [63:0] c_q;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] m;

  always_comb begin
    ma = a_q[31:0];
    mb = c_q[31:0];
    if (step == 2'd2) begin
      mb = c_q[63:32];
    end else if (step == 2'd3) begin
      ma = a_q[63:32];
    end
    m = {32'd0, ma} * {32'd0, mb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= !start && (step == 2'd3);
      if (start) begin
        step <= 2'd1;
      end else if (step == 2'd3) begin
        step <= 2'd0;
      end else if (step != 2'd0) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      c_q <= c;
    end
    if (step == 2'd1) begin
      p <= m;
    end else if (step != 2'd0) begin
      p <= p + {m[31:0], 32'd0};
    end
  end
endmodule

/* hw/rtl/mt19937_64_generator.sv */
// 64-bit Mersenne Twister word generator, standard or dense three-tap variant.
// Requests arrive on req (valid/ready); each transaction carries a restart
// bit. Every request yields exactly one transaction on rsp carrying a tempered
// 64-bit random_word. The table lives in a chain of 312 word cells that shift
// toward the head; a new word is built from fixed taps and enters at the tail,
// so one twist step is done per request instead of a pass over the table.
// A request without reseed goes to S_GEN, where its word is built and registered;
// rsp.valid rises as the block returns to S_IDLE and can take the next request.
// A reseed (restart set, or the first request after reset) shifts 312 seeded
// words in; each word takes one 64-bit multiply done as three 32x32 steps in
// the standard variant and two such multiplies in the dense one, all on the
// shared partial-product multiplier.
// Reset clears the control state and returns seed to 5489 and variant to 0;
// the table is left as is and filled on the first request.
// If the receiver stalls, the finished word stays in the output register and
// one more request is accepted; its word waits until the output frees up.
// Configuration (seed, variant) is written through cfg_wr_en/cfg_index/cfg_data;
// the user must write it only while the block is idle, as the block has no check.
module mt19937_64_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  mt64_req_if.sink    req,
  mt64_rsp_if.source  rsp
);
  import mt64_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [63:0] seed;
  logic        variant;
  logic        seeded;
  logic        twist_var;   // variant latched at the start of each table pass
  pos_t        pos;         // words taken from the current pass; TableLen = pass done
  pos_t        idx;         // fill index
  logic [63:0] s;           // seeding generator state
  logic [31:0] hi;
  logic        rsp_valid;
  logic [63:0] rsp_word;

  logic [63:0] cells [TableLen+1];
  logic        shift;
  logic [63:0] tail_word;

  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] mul_inc;

  logic        pass_start;
  logic        use_dense;
  logic [63:0] y;
  logic [63:0] tw;
  logic [63:0] gen_word;
  logic        fill_push;
  logic [63:0] fill_word;
  logic        gen_go;

  // Word chain: cell k takes the word of cell k+1; the tail takes the new word.
  assign cells[TableLen] = tail_word;
  for (genvar k = 0; k < TableLen; k++) begin : g_chain
    mt64_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (cells[k+1]),
      .q     (cells[k])
    );
  end

  mt64_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .c     (variant ? MUL_DENSE : MUL_STD),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Next word of the recurrence from the head taps.
  always_comb begin
    pass_start = (pos == pos_t'(TableLen));
    use_dense  = pass_start ? variant : twist_var;
    y  = {cells[0][63:31], cells[1][30:0]};
    tw = (y >> 1) ^ (y[0] ? (use_dense ? MAT_DENSE : MAT_STD) : 64'd0);
    if (use_dense) begin
      gen_word = tw ^ cells[TapA] ^ cells[TapB] ^ cells[TapC];
    end else begin
      gen_word = tw ^ cells[MidStd];
    end
  end

  assign gen_go  = (state == S_GEN) && !(rsp_valid && !rsp.ready);
  assign mul_inc = variant ? 64'd1 : (64'(idx) + 64'd1);

  always_comb begin
    fill_push = 1'b0;
    fill_word = s;
    if (mul_done && state == S_MUL1 && !variant) begin
      fill_push = 1'b1;
    end else if (mul_done && state == S_MUL2) begin
      fill_push = 1'b1;
      fill_word = {hi, s[63:32]};
    end
    shift     = fill_push || gen_go;
    tail_word = fill_push ? fill_word : gen_word;
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = variant ? s : (s ^ (s >> 62));
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.restart || !seeded) ? S_LOAD : S_GEN;
        end
      end
      S_LOAD: begin
        mul_start  = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        if (mul_done) begin
          if (variant) begin
            mul_start  = 1'b1;
            mul_a      = mul_p + 64'd1;
            state_next = S_MUL2;
          end else begin
            state_next = (idx == pos_t'(TableLen - 1)) ? S_GEN : S_LOAD;
          end
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          state_next = (idx == pos_t'(TableLen - 1)) ? S_GEN : S_LOAD;
        end
      end
      S_GEN: begin
        if (gen_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_RESET;
      variant   <= 1'b0;
      seeded    <= 1'b0;
      pos       <= pos_t'(TableLen);
      twist_var <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SEED:    seed    <= cfg_data;
          REG_VARIANT: variant <= cfg_data[0];
          default: ;
        endcase
      end
      if (fill_push && idx == pos_t'(TableLen - 1)) begin
        seeded <= 1'b1;
        pos    <= pos_t'(TableLen);
      end
      if (gen_go) begin
        if (pass_start) begin
          twist_var <= variant;
          pos       <= 9'd1;
        end else begin
          pos <= pos + 9'd1;
        end
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      s   <= seed;
      idx <= '0;
    end
    if (mul_done && state == S_MUL1) begin
      if (variant) begin
        hi <= s[63:32];
      end else begin
        idx <= idx + 9'd1;
      end
      s <= mul_p + mul_inc;
    end
    if (mul_done && state == S_MUL2) begin
      s   <= mul_p + 64'd1;
      idx <= idx + 9'd1;
    end
    if (gen_go) begin
      rsp_word <= temper(gen_word, variant);
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.random_word = rsp_word;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= pos_t'(TableLen))
    else $error("read position beyond table");
  a_gen_valid: assert property (@(posedge clk) disable iff (rst)
    gen_go |=> rsp_valid)
    else $error("generated word not presented");
  a_idle_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN) |-> (seeded || (idx == pos_t'(TableLen - 1))))
    else $error("word generated from an unfilled table");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL1 || state == S_MUL2))
    else $error("multiplier result outside seeding");
`endif

endmodule

/* tb/sv/mt19937_64_generator_tb.sv */
`timescale 1ns / 100ps

module mt19937_64_generator_tb;
  import mt64_pkg::*;

  // Traffic shapes used by the driver and by the response side.
  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_DST_STALL,
    FLOW_BOTH
  } flow_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [63:0] cfg_data;

  mt64_req_if req ();
  mt64_rsp_if rsp ();

  mt19937_64_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // Predictor state: the table, the read position and the seeded flag,
  // plus our own copies of the two configuration registers.
  logic [63:0] gen_table [TableLen];
  int unsigned gen_pos;
  bit          gen_seeded;
  logic [63:0] gen_seed;
  logic        gen_dense;

  // Restart bits still waiting to be offered, and words still owed by the block.
  bit          pending_restarts [$];
  logic [63:0] owed_words [$];

  flow_t flow;
  int    hold_off;      // remaining cycles of a long receiver hold-off
  int    errors;
  bit    took_req;      // a request transaction completed at the last rising edge

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Seeding of the whole table from the current seed and variant.
  function automatic void seed_table();
    logic [63:0] s;
    logic [63:0] hi;
    logic [63:0] lo;
    s = gen_seed;
    for (int i = 0; i < TableLen; i++) begin
      if (!gen_dense) begin
        gen_table[i] = s;
        s = MUL_STD * (s ^ (s >> 62)) + 64'(i + 1);
      end else begin
        hi = s & 64'hFFFFFFFF00000000;
        s = MUL_DENSE * s + 64'd1;
        lo = s >> 32;
        s = MUL_DENSE * s + 64'd1;
        gen_table[i] = hi | lo;
      end
    end
    gen_pos = TableLen;
  endfunction

  function automatic int unsigned wrap(int unsigned i);
    return (i >= TableLen) ? i - TableLen : i;
  endfunction

  // One full twist pass done in place, so later entries see updated neighbors.
  function automatic void twist_table();
    logic [63:0] y;
    logic [63:0] v;
    for (int unsigned i = 0; i < TableLen; i++) begin
      y = (gen_table[i] & 64'hFFFFFFFF80000000) | (gen_table[wrap(i + 1)] & 64'h7FFFFFFF);
      v = (y >> 1) ^ (y[0] ? (gen_dense ? MAT_DENSE : MAT_STD) : 64'd0);
      if (!gen_dense) begin
        gen_table[i] = gen_table[wrap(i + MidStd)] ^ v;
      end else begin
        gen_table[i] = v ^ gen_table[wrap(i + TapA)] ^ gen_table[wrap(i + TapB)]
                       ^ gen_table[wrap(i + TapC)];
      end
    end
    gen_pos = 0;
  endfunction

  function automatic logic [63:0] scramble(logic [63:0] w);
    if (!gen_dense) begin
      w ^= (w >> 29) & 64'h5555555555555555;
      w ^= (w << 17) & 64'h71D67FFFEDA60000;
      w ^= (w << 37) & 64'hFFF7EEE000000000;
      w ^= w >> 43;
    end else begin
      w ^= w >> 26;
      w ^= (w << 17) & 64'h599CFCBFCA660000;
      w ^= (w << 33) & 64'hFFFAAFFE00000000;
      w ^= w >> 39;
    end
    return w;
  endfunction

  function automatic logic [63:0] next_word(bit restart);
    logic [63:0] w;
    if (restart || !gen_seeded) begin
      seed_table();
      gen_seeded = 1'b1;
    end
    if (gen_pos >= TableLen) twist_table();
    w = gen_table[gen_pos];
    gen_pos = (gen_pos + 1) & 9'h1FF;
    return scramble(w);
  endfunction

  // Monitor: both handshakes are sampled at the rising edge. A request
  // transaction is predicted on the spot; a response transaction is checked
  // against the oldest owed word. A response cannot belong to a request taken
  // in the same cycle, so the order of the two steps does not matter.
  always @(posedge clk) begin
    logic [63:0] want;
    took_req <= !rst && req.valid && req.ready;
    if (!rst) begin
      if (req.valid && req.ready) begin
        owed_words.push_back(next_word(req.restart));
        void'(pending_restarts.pop_front());
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_words.size() == 0) begin
          $error("random_word: unexpected transaction, actual %h", rsp.random_word);
          errors++;
        end else begin
          want = owed_words.pop_front();
          if (rsp.random_word !== want) begin
            $error("random_word: expected %h, actual %h", want, rsp.random_word);
            errors++;
          end
        end
      end
    end
  end

  // Driver: inputs move on the falling edge. An offered request stays up
  // until it is taken; only then may the sender go idle for a while.
  always @(negedge clk) begin
    bit offer;
    if (rst) begin
      req.valid   <= 1'b0;
      req.restart <= 1'b0;
    end else begin
      if (req.valid && !took_req) begin
        offer = 1'b1;
      end else begin
        offer = pending_restarts.size() > 0;
        if (flow == FLOW_SRC_IDLE && $urandom_range(99) < 55) offer = 1'b0;
        if (flow == FLOW_BOTH && $urandom_range(99) < 10) offer = 1'b0;
      end
      // After a take the queue head has already moved to the next item.
      if (offer && pending_restarts.size() > 0) begin
        req.valid   <= 1'b1;
        req.restart <= pending_restarts[0];
      end else begin
        req.valid   <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random under FLOW_DST_STALL and FLOW_BOTH, or holds off for a
  // long counted stretch so the block fills up and pushes back on the request side.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off > 0) begin
      rsp.ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      case (flow)
        FLOW_DST_STALL: rsp.ready <= ($urandom_range(99) >= 55);
        FLOW_BOTH:      rsp.ready <= ($urandom_range(99) >= 10);
        default:        rsp.ready <= 1'b1;
      endcase
    end
  end

  // Register writes happen only while nothing is in flight.
  task automatic write_reg(logic idx, logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_SEED) gen_seed = value;
    else gen_dense = value[0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_restarts.size() != 0 || owed_words.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic queue_burst(int count, int restart_pct);
    for (int i = 0; i < count; i++)
      pending_restarts.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    logic [63:0] s;
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_SEED;
    cfg_data  = '0;
    req.valid   = 1'b0;
    req.restart = 1'b0;
    rsp.ready   = 1'b0;
    flow      = FLOW_FREE;
    hold_off  = 0;
    errors    = 0;
    took_req  = 1'b0;
    gen_seed   = SEED_RESET;
    gen_dense  = 1'b0;
    gen_pos    = TableLen;
    gen_seeded = 1'b0;
    foreach (gen_table[i]) gen_table[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The first request after reset has restart low and must
    // still seed from the reset seed; then an explicit restart follows.
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    drain();
    // Seed at its lowest value in the standard variant.
    write_reg(REG_SEED, 64'd0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    drain();
    // Seed at its highest value in the dense variant.
    write_reg(REG_SEED, '1);
    write_reg(REG_VARIANT, 1'b1);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    drain();
    // Variant flipped without restart: old table, old twist until the next pass, new tempering.
    write_reg(REG_VARIANT, 1'b0);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);
    drain();
    // Seed changed without restart has no effect until the next reseed.
    write_reg(REG_SEED, 64'h0123456789ABCDEF);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    drain();

    // Random part, one phase per traffic shape. Bursts are shorter than a full
    // table, so they stay within the first table regeneration after each reseed.
    for (int ph = 0; ph < 4; ph++) begin
      s = {$urandom, $urandom};
      write_reg(REG_SEED, s);
      write_reg(REG_VARIANT, ph[0]);
      flow = flow_t'(ph);
      pending_restarts.push_back(1'b1);
      if (ph == 0) begin
        // Long receiver hold-off while requests keep coming; it outlasts the
        // reseed so that a finished word waits behind a stalled output and requests back up.
        queue_burst(20, 0);
        hold_off = 2000;
      end
      queue_burst(215, 1);
      drain();
    end
    // Variant swapped mid-stream without restart, under mixed traffic.
    write_reg(REG_VARIANT, 1'b1);
    flow = FLOW_BOTH;
    queue_burst(60, 2);
    drain();
    flow = FLOW_FREE;
    repeat (50) @(negedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
